// File: rtl/ps2_mouse_packet_decoder_macros.svh
// Assertion macros shared by the PS/2 mouse packet decoder RTL.
`ifndef PS2_MOUSE_PACKET_DECODER_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define PS2MPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2mpd: implication check failed");
`define PS2MPD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ps2mpd: forbidden condition seen");
`else
`define PS2MPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PS2MPD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/ps2mpd_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
package ps2mpd_pkg;

    localparam int POS_WIDTH_DEF = 16;
    localparam int CMD_DEPTH     = 2;

    // Status byte layout
    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;
    localparam logic [7:0] OVF_MASK = 8'hC0;

    typedef enum logic [1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_WHEEL_MODE    = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_DATA    = 1'b0,
        OP_SET_POS = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        EV_REL_X      = 3'd0,
        EV_REL_Y      = 3'd1,
        EV_WHEEL      = 3'd2,
        EV_BTN_LEFT   = 3'd3,
        EV_BTN_RIGHT  = 3'd4,
        EV_BTN_MIDDLE = 3'd5,
        EV_SYNC       = 3'd6
    } event_kind_t;

    // Classified work item handed from front to back
    typedef struct packed {
        op_t         op;
        logic [8:0]  dx;       // signed, sign from status byte
        logic [9:0]  dy;       // signed, already negated
        logic [7:0]  scroll;   // signed wheel byte, zero when unused
        logic [2:0]  buttons;
        logic [15:0] new_x;
        logic [15:0] new_y;
    } cmd_t;

    // Clamp bounds and recenter strobe for the back end
    typedef struct packed {
        logic        recenter;
        logic [14:0] width;
        logic [14:0] height;
    } bounds_t;

endpackage

// File: rtl/ps2_mouse_packet_decoder.sv
// Top level of the PS/2 mouse packet decoder: config registers, front, queue, back.
//
// Input channel (in_valid/in_ready): op selects a mouse data byte (data_byte)
// or a set-position request (new_x/new_y); bytes may arrive back to back
// while the queue has room. Packets of 3 bytes, or 4 with wheel_mode, become
// one command; overflow packets are dropped early.
// Output channel (out_valid/out_ready): one transfer per event, ending with a
// sync event that has last set. A packet yields 1 to 7 events. The back end's
// event sequencer moves one event per cycle while the receiver is ready, and
// pops the next command only when no event is pending, so it does not start a
// new packet before the last run is done. A completing byte passes through the
// command queue and the pending-event register before out_valid rises.
// A stalled receiver holds the output register; the two-entry command queue
// keeps taking bytes until it fills, then in_ready drops.
// Config port: cfg_wr_en writes cfg_data into register cfg_index at once;
// writing either screen bound recenters the cursor.
// Reset clears the packet index, cursor, button state, queue and registers;
// in_ready is high as soon as reset is released.
`include "ps2_mouse_packet_decoder_macros.svh"
module ps2_mouse_packet_decoder
#(
    parameter int POS_WIDTH = ps2mpd_pkg::POS_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    input  logic [15:0] new_x,
    input  logic [15:0] new_y,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  event_kind,
    output logic [9:0]  event_value,
    output logic [15:0] cursor_x,
    output logic [15:0] cursor_y,
    output logic        last
);

    logic [14:0] width_reg, width_next;
    logic [14:0] height_reg, height_next;
    logic        wheel_reg, wheel_next;

    ps2mpd_pkg::bounds_t bounds;
    ps2mpd_pkg::cmd_t    push_cmd;
    ps2mpd_pkg::cmd_t    pop_cmd;
    logic                cmd_push;
    logic                cmd_pop;
    logic                cmd_full;
    logic                cmd_empty;

    // Decode configuration writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        wheel_next  = wheel_reg;
        if (cfg_wr_en)
        begin
            case (ps2mpd_pkg::cfg_index_t'(cfg_index))
                ps2mpd_pkg::CFG_SCREEN_WIDTH:  width_next  = cfg_data;
                ps2mpd_pkg::CFG_SCREEN_HEIGHT: height_next = cfg_data;
                ps2mpd_pkg::CFG_WHEEL_MODE:    wheel_next  = cfg_data[0];
                default:                       ;
            endcase
        end
        bounds.recenter = cfg_wr_en &&
            (cfg_index == ps2mpd_pkg::CFG_SCREEN_WIDTH ||
             cfg_index == ps2mpd_pkg::CFG_SCREEN_HEIGHT);
        bounds.width    = width_next;
        bounds.height   = height_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 15'd0;
            height_reg <= 15'd0;
            wheel_reg  <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            wheel_reg  <= wheel_next;
        end
    end

    ps2mpd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .data_byte  (data_byte),
        .new_x      (new_x),
        .new_y      (new_y),
        .wheel_mode (wheel_reg),
        .cmd_push   (cmd_push),
        .cmd        (push_cmd),
        .cmd_full   (cmd_full)
    );

    ps2mpd_cmd_fifo #(.DEPTH(ps2mpd_pkg::CMD_DEPTH)) u_cmd_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (push_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (pop_cmd),
        .empty (cmd_empty)
    );

    ps2mpd_back #(.POS_WIDTH(POS_WIDTH)) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .bounds      (bounds),
        .cmd_empty   (cmd_empty),
        .cmd         (pop_cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .event_value (event_value),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y),
        .last        (last)
    );

    // Sync events and only sync events close a run
    `PS2MPD_ASSERT_IMPLY(a_last_on_sync, clk, rst_n, out_valid, last == (event_kind == ps2mpd_pkg::EV_SYNC))
    // Button events carry only press or release
    `PS2MPD_ASSERT_IMPLY(a_button_value, clk, rst_n, out_valid && (event_kind == ps2mpd_pkg::EV_BTN_LEFT || event_kind == ps2mpd_pkg::EV_BTN_RIGHT || event_kind == ps2mpd_pkg::EV_BTN_MIDDLE), event_value[9:1] == 9'd0)
    // Relative X events are never empty
    `PS2MPD_ASSERT_NEVER(a_rel_x_nonzero, clk, rst_n, out_valid && event_kind == ps2mpd_pkg::EV_REL_X && event_value == 10'd0)
    // Clamped cursor stays inside the screen
    `PS2MPD_ASSERT_IMPLY(a_cursor_in_bounds, clk, rst_n, out_valid && width_reg != 15'd0 && height_reg != 15'd0, !cursor_x[15] && cursor_x[14:0] < width_reg && !cursor_y[15] && cursor_y[14:0] < height_reg)

endmodule

// File: rtl/ps2mpd_front.sv
// Front end: accepts bytes and set-position items, assembles packets into commands.
module ps2mpd_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              op,
    input  logic [7:0]        data_byte,
    input  logic [15:0]       new_x,
    input  logic [15:0]       new_y,
    input  logic              wheel_mode,
    output logic              cmd_push,
    output ps2mpd_pkg::cmd_t  cmd,
    input  logic              cmd_full
);

    logic [1:0] byte_index_reg;
    logic [1:0] byte_index_next;
    logic [7:0] pkt_reg [3];

    logic       accept;
    logic       is_data;
    logic       sync_ok;
    logic       completing;
    logic [7:0] status;
    logic [7:0] third;
    logic [9:0] dy_raw;

    // Stall only on a full command queue
    assign in_ready = !cmd_full;
    assign accept   = in_valid && in_ready;
    assign is_data  = (op == ps2mpd_pkg::OP_DATA);

    // Classify the incoming byte
    always_comb
    begin
        sync_ok    = (byte_index_reg != 2'd0) || data_byte[ps2mpd_pkg::SYNC_BIT];
        completing = wheel_mode ? (byte_index_reg == 2'd3) : (byte_index_reg >= 2'd2);
        status     = pkt_reg[0];
        third      = (byte_index_reg == 2'd2) ? data_byte : pkt_reg[2];
        dy_raw     = {status[ps2mpd_pkg::YSIGN_BIT], status[ps2mpd_pkg::YSIGN_BIT], third};

        cmd.op      = ps2mpd_pkg::op_t'(op);
        cmd.dx      = {status[ps2mpd_pkg::XSIGN_BIT], pkt_reg[1]};
        cmd.dy      = ~dy_raw + 10'd1;
        cmd.scroll  = (wheel_mode && byte_index_reg == 2'd3) ? data_byte : 8'd0;
        cmd.buttons = status[2:0];
        cmd.new_x   = new_x;
        cmd.new_y   = new_y;

        // Drop overflow packets here; they leave no trace downstream
        cmd_push = accept && (!is_data ||
                   (sync_ok && completing && ((status & ps2mpd_pkg::OVF_MASK) == 8'd0)));

        byte_index_next = byte_index_reg;
        if (accept && is_data && sync_ok)
        begin
            byte_index_next = completing ? 2'd0 : byte_index_reg + 2'd1;
        end
    end

    // Hold the packet index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= 2'd0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
        end
    end

    // Store non-completing packet bytes
    always_ff @(posedge clk)
    begin
        if (accept && is_data && sync_ok && !completing)
        begin
            pkt_reg[byte_index_reg] <= data_byte;
        end
    end

endmodule

// File: rtl/ps2mpd_cmd_fifo.sv
// Short command queue between the front and back ends.
module ps2mpd_cmd_fifo
#(
    parameter int DEPTH = ps2mpd_pkg::CMD_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ps2mpd_pkg::cmd_t  wdata,
    output logic              full,
    input  logic              pop,
    output ps2mpd_pkg::cmd_t  rdata,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ps2mpd_pkg::cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/ps2mpd_back.sv
// Back end: updates cursor position and emits the event run for each packet.
module ps2mpd_back
#(
    parameter int POS_WIDTH = ps2mpd_pkg::POS_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ps2mpd_pkg::bounds_t  bounds,
    input  logic                 cmd_empty,
    input  ps2mpd_pkg::cmd_t     cmd,
    output logic                 cmd_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           event_kind,
    output logic [9:0]           event_value,
    output logic [15:0]          cursor_x,
    output logic [15:0]          cursor_y,
    output logic                 last
);

    localparam int EXT_W = (POS_WIDTH > 16) ? POS_WIDTH : 16;
    localparam int SUM_W = EXT_W + 1;
    localparam logic signed [SUM_W-1:0] POS_MAX =
        $signed({{(SUM_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}});
    localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;

    logic signed [POS_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic [2:0]  prev_buttons_reg, prev_buttons_next;
    logic [6:0]  pend_reg, pend_next;
    logic [8:0]  dx_reg, dx_next;
    logic [9:0]  dy_reg, dy_next;
    logic [7:0]  scroll_reg, scroll_next;
    logic [2:0]  buttons_reg, buttons_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  event_kind_reg, event_kind_next;
    logic [9:0]  event_value_reg, event_value_next;
    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic        last_reg, last_next;

    logic                    clamp_en;
    logic signed [SUM_W-1:0] raw_x;
    logic signed [SUM_W-1:0] raw_y;
    logic signed [EXT_W-1:0] ext_x;
    logic signed [EXT_W-1:0] ext_y;
    logic [2:0]              changed;
    logic [2:0]              sel;
    logic                    load;

    // Clamp to [0, bound-1] when enabled, then saturate to the position range
    function automatic logic signed [SUM_W-1:0] clamp_axis(
        input logic signed [SUM_W-1:0] v,
        input logic [14:0]             bound,
        input logic                    en
    );
        logic signed [SUM_W-1:0] r;
        logic signed [SUM_W-1:0] b_s;
        b_s = $signed({{(SUM_W - 15){1'b0}}, bound});
        r   = v;
        if (en)
        begin
            if (r < 0)
            begin
                r = '0;
            end
            if (r >= b_s)
            begin
                r = b_s - 1'b1;
            end
        end
        if (r > POS_MAX)
        begin
            r = POS_MAX;
        end
        else if (r < POS_MIN)
        begin
            r = POS_MIN;
        end
        return r;
    endfunction

    assign clamp_en = (bounds.width != 15'd0) && (bounds.height != 15'd0);
    assign cmd_pop  = !cmd_empty && (pend_reg == 7'd0);
    assign load     = !out_valid_reg || out_ready;
    assign changed  = cmd.buttons ^ prev_buttons_reg;
    assign ext_x    = EXT_W'(pos_x_reg);
    assign ext_y    = EXT_W'(pos_y_reg);

    // Position update and event scheduling
    always_comb
    begin
        pos_x_next        = pos_x_reg;
        pos_y_next        = pos_y_reg;
        prev_buttons_next = prev_buttons_reg;
        pend_next         = pend_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        scroll_next       = scroll_reg;
        buttons_next      = buttons_reg;
        out_valid_next    = out_valid_reg;
        event_kind_next   = event_kind_reg;
        event_value_next  = event_value_reg;
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        last_next         = last_reg;
        sel               = 3'd0;

        if (cmd.op == ps2mpd_pkg::OP_SET_POS)
        begin
            raw_x = SUM_W'($signed(cmd.new_x));
            raw_y = SUM_W'($signed(cmd.new_y));
        end
        else
        begin
            raw_x = SUM_W'(pos_x_reg) + SUM_W'($signed(cmd.dx));
            raw_y = SUM_W'(pos_y_reg) + SUM_W'($signed(cmd.dy));
        end

        // Recenter on bound writes, else take a command when the run is done
        if (bounds.recenter)
        begin
            pos_x_next = POS_WIDTH'(clamp_axis($signed({{(SUM_W - 14){1'b0}},
                                    bounds.width[14:1]}), bounds.width, 1'b0));
            pos_y_next = POS_WIDTH'(clamp_axis($signed({{(SUM_W - 14){1'b0}},
                                    bounds.height[14:1]}), bounds.height, 1'b0));
        end
        else if (cmd_pop)
        begin
            pos_x_next = POS_WIDTH'(clamp_axis(raw_x, bounds.width, clamp_en));
            pos_y_next = POS_WIDTH'(clamp_axis(raw_y, bounds.height, clamp_en));
            if (cmd.op == ps2mpd_pkg::OP_DATA)
            begin
                prev_buttons_next = cmd.buttons;
                dx_next           = cmd.dx;
                dy_next           = cmd.dy;
                scroll_next       = cmd.scroll;
                buttons_next      = cmd.buttons;
                pend_next = {1'b1, changed, (cmd.scroll != 8'd0),
                             (cmd.dy != 10'd0), (cmd.dx != 9'd0)};
            end
        end

        // Pick the lowest pending event
        for (int i = 6; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel = 3'(i);
            end
        end

        // Move one event into the output register
        if (load)
        begin
            out_valid_next = (pend_reg != 7'd0);
            if (pend_reg != 7'd0)
            begin
                pend_next[sel]  = 1'b0;
                event_kind_next = sel;
                cursor_x_next   = ext_x[15:0];
                cursor_y_next   = ext_y[15:0];
                last_next       = (sel == ps2mpd_pkg::EV_SYNC);
                case (ps2mpd_pkg::event_kind_t'(sel))
                    ps2mpd_pkg::EV_REL_X:      event_value_next = {dx_reg[8], dx_reg};
                    ps2mpd_pkg::EV_REL_Y:      event_value_next = dy_reg;
                    ps2mpd_pkg::EV_WHEEL:      event_value_next = {{2{scroll_reg[7]}}, scroll_reg};
                    ps2mpd_pkg::EV_BTN_LEFT:   event_value_next = {9'd0, buttons_reg[0]};
                    ps2mpd_pkg::EV_BTN_RIGHT:  event_value_next = {9'd0, buttons_reg[1]};
                    ps2mpd_pkg::EV_BTN_MIDDLE: event_value_next = {9'd0, buttons_reg[2]};
                    default:                   event_value_next = 10'd0;
                endcase
            end
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            prev_buttons_reg <= 3'd0;
            pend_reg         <= 7'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            pos_x_reg        <= pos_x_next;
            pos_y_reg        <= pos_y_next;
            prev_buttons_reg <= prev_buttons_next;
            pend_reg         <= pend_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        dx_reg          <= dx_next;
        dy_reg          <= dy_next;
        scroll_reg      <= scroll_next;
        buttons_reg     <= buttons_next;
        event_kind_reg  <= event_kind_next;
        event_value_reg <= event_value_next;
        cursor_x_reg    <= cursor_x_next;
        cursor_y_reg    <= cursor_y_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign event_kind  = event_kind_reg;
    assign event_value = event_value_reg;
    assign cursor_x    = cursor_x_reg;
    assign cursor_y    = cursor_y_reg;
    assign last        = last_reg;

endmodule

// File: test/ps2_mouse_packet_decoder_tb.sv
// Self-checking testbench for the PS/2 mouse packet decoder: directed cases plus random traffic.
module ps2_mouse_packet_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2mpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;
    localparam int IDLE_PCT       = 14;
    localparam int POS_MAX        = 32767;
    localparam int POS_MIN        = -32768;
    localparam int REPORT_CAP     = 40;

    typedef struct {
        event_kind_t kind;
        logic [9:0]  value;
        logic [15:0] cx;
        logic [15:0] cy;
        logic        last;
    } mouse_event_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_SCREEN_WIDTH;
    logic [14:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        op = OP_DATA;
    logic [7:0]  data_byte = '0;
    logic [15:0] new_x = '0;
    logic [15:0] new_y = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  event_kind;
    logic [9:0]  event_value;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
    logic        last;

    // Mirror of the decoder state and registers
    int unsigned  bound_w;
    int unsigned  bound_h;
    bit           wheel_on;
    int           frame_idx;
    logic [7:0]   frame_bytes [3];
    int           cur_x;
    int           cur_y;
    logic [2:0]   btn_state;

    mouse_event_t pending_events [$];
    int           items_sent;
    int           events_seen;
    int           err_count;
    int           phase_count;
    bit           sender_idles;
    bit           receiver_idles;

    ps2_mouse_packet_decoder u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .data_byte   (data_byte),
        .new_x       (new_x),
        .new_y       (new_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .event_value (event_value),
        .cursor_x    (cursor_x),
        .cursor_y    (cursor_y),
        .last        (last)
    );

    always #2 clk = ~clk;

    // Hold off the receiver at random while idling is enabled
    always @(negedge clk)
    begin
        out_ready <= receiver_idles ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    function automatic int saturate_pos(int v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < POS_MIN)
            return POS_MIN;
        return v;
    endfunction

    // Clamp only when both bounds are set, then saturate to the position width
    function automatic int bound_axis(int v, int unsigned bound);
        if (bound_w != 0 && bound_h != 0)
        begin
            if (v < 0)
                v = 0;
            if (v >= int'(bound))
                v = int'(bound) - 1;
        end
        return saturate_pos(v);
    endfunction

    function automatic void push_event(event_kind_t k, int val, logic lst);
        mouse_event_t ev;
        ev.kind  = k;
        ev.value = val[9:0];
        ev.cx    = cur_x[15:0];
        ev.cy    = cur_y[15:0];
        ev.last  = lst;
        pending_events.push_back(ev);
    endfunction

    function automatic void apply_reg(cfg_index_t idx, logic [14:0] d);
        case (idx)
            CFG_SCREEN_WIDTH:  bound_w = {17'd0, d};
            CFG_SCREEN_HEIGHT: bound_h = {17'd0, d};
            CFG_WHEEL_MODE:    wheel_on = d[0];
            default: ;
        endcase
        // Either bound recenters the cursor
        if (idx == CFG_SCREEN_WIDTH || idx == CFG_SCREEN_HEIGHT)
        begin
            cur_x = saturate_pos(int'(bound_w / 2));
            cur_y = saturate_pos(int'(bound_h / 2));
        end
    endfunction

    // Decode one accepted item into expected events; return 0 when a byte lacks the sync bit
    function automatic bit decode_item(op_t o, logic [7:0] b, logic [15:0] nx,
                                       logic [15:0] ny);
        int         size;
        int         dx;
        int         dy;
        int         scroll;
        int         sx;
        int         sy;
        logic [7:0] st;
        logic [2:0] chg;
        if (o == OP_SET_POS)
        begin
            sx = 32'($signed(nx));
            sy = 32'($signed(ny));
            cur_x = bound_axis(sx, bound_w);
            cur_y = bound_axis(sy, bound_h);
            return 1'b1;
        end
        if (frame_idx == 0 && !b[SYNC_BIT])
            return 1'b0;
        size = wheel_on ? 4 : 3;
        if (frame_idx + 1 < size)
        begin
            if (frame_idx < 3)
                frame_bytes[frame_idx] = b;
            frame_idx = (frame_idx + 1) % 4;
            return 1'b1;
        end
        // Completing byte
        scroll = 0;
        if (frame_idx < 3)
            frame_bytes[frame_idx] = b;
        else if (wheel_on)
            scroll = 32'($signed(b));
        frame_idx = 0;
        st = frame_bytes[0];
        if ((st & OVF_MASK) != 8'h00)
            return 1'b1;
        dx = int'(frame_bytes[1]) - (st[XSIGN_BIT] ? 256 : 0);
        dy = -(int'(frame_bytes[2]) - (st[YSIGN_BIT] ? 256 : 0));
        cur_x = bound_axis(cur_x + dx, bound_w);
        cur_y = bound_axis(cur_y + dy, bound_h);
        if (dx != 0)
            push_event(EV_REL_X, dx, 1'b0);
        if (dy != 0)
            push_event(EV_REL_Y, dy, 1'b0);
        if (scroll != 0)
            push_event(EV_WHEEL, scroll, 1'b0);
        chg = st[2:0] ^ btn_state;
        if (chg[0])
            push_event(EV_BTN_LEFT, int'(st[0]), 1'b0);
        if (chg[1])
            push_event(EV_BTN_RIGHT, int'(st[1]), 1'b0);
        if (chg[2])
            push_event(EV_BTN_MIDDLE, int'(st[2]), 1'b0);
        btn_state = st[2:0];
        push_event(EV_SYNC, 0, 1'b1);
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= REPORT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Compare each output transfer with the oldest expected event
    always @(posedge clk)
    begin : event_check
        mouse_event_t want;
        if (rst_n && out_valid && out_ready)
        begin
            events_seen++;
            if (pending_events.size() == 0)
                report_mismatch($sformatf("unexpected event kind %0d value %0d",
                                          event_kind, $signed(event_value)));
            else
            begin
                want = pending_events.pop_front();
                if (event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0d, want %0d",
                                              event_kind, want.kind));
                if (event_value !== want.value)
                    report_mismatch($sformatf("event_value %0d, want %0d (kind %0d)",
                                              $signed(event_value), $signed(want.value),
                                              want.kind));
                if (cursor_x !== want.cx)
                    report_mismatch($sformatf("cursor_x %0d, want %0d",
                                              $signed(cursor_x), $signed(want.cx)));
                if (cursor_y !== want.cy)
                    report_mismatch($sformatf("cursor_y %0d, want %0d",
                                              $signed(cursor_y), $signed(want.cy)));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, want %0b", last, want.last));
            end
        end
    end

    // End the run when no transfer happens for too long while work is pending
    initial
    begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stuck_cycles = 0;
            else if (in_valid || pending_events.size() != 0)
                stuck_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("ps2_mouse_packet_decoder regression: fail");
        $finish;
    end

    // Present one item and hold it until the transfer
    task automatic send_item(op_t o, logic [7:0] b, logic [15:0] nx, logic [15:0] ny);
        @(negedge clk);
        while (sender_idles && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        data_byte <= b;
        new_x     <= nx;
        new_y     <= ny;
        do
            @(posedge clk);
        while (!in_ready);
        if (decode_item(o, b, nx, ny))
            items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(OP_DATA, b, 16'($urandom), 16'($urandom));
    endtask

    task automatic set_position(logic [15:0] nx, logic [15:0] ny);
        send_item(OP_SET_POS, 8'($urandom), nx, ny);
    endtask

    // Send a full packet; the wheel byte goes out only in wheel mode
    task automatic send_packet(logic [7:0] s, logic [7:0] d1, logic [7:0] d2,
                               logic [7:0] w);
        send_byte(s);
        send_byte(d1);
        send_byte(d2);
        if (wheel_on)
            send_byte(w);
    endtask

    // Drop valid, wait for every expected event, then let queued commands drain
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [14:0] d);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        apply_reg(idx, d);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sync bit, sign extremes, overflow discard and saturation with no bounds
    task automatic test_basic_packets();
        send_byte(8'h00);
        send_packet(8'h09, 8'h01, 8'h01, 8'h00);
        send_packet(8'h3E, 8'h00, 8'h00, 8'h00);
        send_packet(8'h08, 8'hFF, 8'hFF, 8'h00);
        send_packet(8'h48, 8'h10, 8'h10, 8'h00);
        send_packet(8'h89, 8'h20, 8'h20, 8'h00);
        set_position(16'h7FFF, 16'h8000);
        send_packet(8'h08, 8'h7F, 8'h7F, 8'h00);
    endtask

    // Clamp to both bounds, then disable clamping with one bound at zero
    task automatic test_clamping();
        settle();
        write_reg(CFG_SCREEN_WIDTH, 15'd100);
        write_reg(CFG_SCREEN_HEIGHT, 15'd50);
        set_position(16'hFFFB, 16'h7FFF);
        send_packet(8'h18, 8'h00, 8'h80, 8'h00);
        send_packet(8'h28, 8'hFF, 8'h00, 8'h00);
        settle();
        write_reg(CFG_SCREEN_HEIGHT, 15'd0);
        send_packet(8'h18, 8'h00, 8'h00, 8'h00);
    endtask

    // Wheel byte, then leave wheel mode with three bytes of a packet held
    task automatic test_wheel_mode();
        settle();
        write_reg(CFG_WHEEL_MODE, 15'd1);
        send_packet(8'h0C, 8'h00, 8'h00, 8'h80);
        send_byte(8'h09);
        send_byte(8'h01);
        send_byte(8'h02);
        settle();
        write_reg(CFG_WHEEL_MODE, 15'd0);
        send_byte(8'h7F);
    endtask

    // One register setting with mostly well-formed packets and some noise
    task automatic random_phase(int unsigned w, int unsigned h, bit wm, bit idles,
                                int quota);
        int          start;
        int          r;
        int          n;
        int          size;
        logic [7:0]  s;
        logic [15:0] px;
        logic [15:0] py;
        settle();
        write_reg(CFG_SCREEN_WIDTH, 15'(w));
        write_reg(CFG_SCREEN_HEIGHT, 15'(h));
        write_reg(CFG_WHEEL_MODE, 15'(wm));
        phase_count++;
        sender_idles   = idles;
        receiver_idles = idles;
        start = items_sent;
        while (items_sent - start < quota)
        begin
            r = $urandom_range(99);
            size = wheel_on ? 4 : 3;
            if (r < 75)
            begin
                s = 8'($urandom);
                s[SYNC_BIT] = 1'b1;
                if ($urandom_range(99) >= 8)
                    s[7:6] = 2'b00;
                send_packet(s, 8'($urandom), 8'($urandom), 8'($urandom));
            end
            else if (r < 85)
            begin
                if ($urandom_range(1) == 1)
                begin
                    px = 16'($urandom);
                    py = 16'($urandom);
                end
                else
                begin
                    px = 16'($urandom_range(w + 4)) - 16'd2;
                    py = 16'($urandom_range(h + 4)) - 16'd2;
                end
                set_position(px, py);
            end
            else if (r < 93)
                send_byte(8'($urandom));
            else
            begin
                // Cut a packet short so the next one lands out of frame
                n = $urandom_range(size - 1, 1);
                s = 8'($urandom);
                s[SYNC_BIT] = 1'b1;
                send_byte(s);
                repeat (n - 1) send_byte(8'($urandom));
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(0, 0, 1'b0, 1'b1, 80);
        random_phase(32767, 32767, 1'b1, 1'b1, 80);
        random_phase(1, 1, 1'b0, 1'b0, 80);
        random_phase(640, 0, 1'b1, 1'b1, 80);
        random_phase($urandom_range(300, 1), $urandom_range(300, 1),
                     1'($urandom_range(1)), 1'b1, 80);
        random_phase(0, 32767, 1'b0, 1'b1, 80);
    endtask

    initial
    begin
        bound_w        = 0;
        bound_h        = 0;
        wheel_on       = 1'b0;
        frame_idx      = 0;
        frame_bytes    = '{default: 8'h00};
        cur_x          = 0;
        cur_y          = 0;
        btn_state      = 3'b000;
        items_sent     = 0;
        events_seen    = 0;
        err_count      = 0;
        phase_count    = 0;
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_packets();
        test_clamping();
        test_wheel_mode();
        test_random_traffic();
        settle();

        $display("covered %0d input items and %0d checked events over %0d random settings",
                 items_sent, events_seen, phase_count);
        $display("bounds from 0 to 32767, wheel mode on and off, %0d mismatches",
                 err_count);
        if (err_count == 0)
            $display("ps2_mouse_packet_decoder regression: pass");
        else
            $display("ps2_mouse_packet_decoder regression: fail");
        $finish;
    end

endmodule
